// ----- sv/ssi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants for the segment set intersection block
// Sizes, command codes, the word formats that pass from the front to the back,
// and the helpers for coordinate conversion and the parameter range test.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int COORD_BITS   = 16;
  localparam int FIELD_W      = 16;

  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int ADDR_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;

  // The queue depth must be a power of two so the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CLEAR,
    OP_TEST
  } op_t;

  typedef struct packed {
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
  } seg_t;

  typedef struct packed {
    op_t  op;
    seg_t seg;
    logic final_test;
  } item_t;

  typedef struct packed {
    logic segment_hit;
    logic shapes_collide;
    logic run_done;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_RESULT
  } back_state_t;

  // Low COORD_BITS bits of a field, read as two's complement.
  function automatic coord_t to_coord(input logic [FIELD_W-1:0] f);
    return coord_t'(f[COORD_BITS-1:0]);
  endfunction

  // True when num/den lies in [0,1]; den is known to be nonzero.
  function automatic logic in_unit(input cross_t num, input cross_t den);
    logic ok;
    if (!den[CROSS_W-1]) begin
      ok = !num[CROSS_W-1] && (num <= den);
    end else begin
      ok = (num[CROSS_W-1] || (num == '0)) && (num >= den);
    end
    return ok;
  endfunction

endpackage

// ----- sv/ssi_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_if: valid/ready channels of the segment set intersection block
// One interface for the command word stream and one for the result stream.
// ----------------------------------------------------------------------------
interface ssi_in_if import ssi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [FIELD_W-1:0] x_start;
  logic signed [FIELD_W-1:0] y_start;
  logic signed [FIELD_W-1:0] x_end;
  logic signed [FIELD_W-1:0] y_end;
  logic               final_test;

  modport source (output valid, output command, output x_start, output y_start,
                  output x_end, output y_end, output final_test, input ready);
  modport sink   (input valid, input command, input x_start, input y_start,
                  input x_end, input y_end, input final_test, output ready);
endinterface

interface ssi_out_if ();
  logic valid;
  logic ready;
  logic segment_hit;
  logic shapes_collide;
  logic run_done;

  modport source (output valid, output segment_hit, output shapes_collide,
                  output run_done, input ready);
  modport sink   (input valid, input segment_hit, input shapes_collide,
                  input run_done, output ready);
endinterface

// ----- sv/segment_set_intersection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_set_intersection: segment set crossing test
// Stores the segments of one shape and reports, for each test segment of a
// second shape, whether it crosses any stored segment, plus a run-wide flag.
//
//   channel | dir | handshake    | word contents
//   in_ch   | in  | valid/ready  | command, x_start, y_start, x_end, y_end,
//           |     |              | final_test
//   out_ch  | out | valid/ready  | segment_hit, shapes_collide, run_done
//
// Load and clear are executed in the execution engine as it pops them; a test
// walks the stored segments through the single read port of the segment
// store, which the walk reads once per cycle.
// Reset is synchronous and active low; it empties the store and the queue.
// A two-word queue keeps in_ch ready while a test runs; a held result stalls
// the engine, and the queue then fills up before in_ch deasserts ready.
// ----------------------------------------------------------------------------
module segment_set_intersection import ssi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ssi_in_if.sink     in_ch,
  ssi_out_if.source  out_ch
);

  logic  push_valid;
  item_t push_item;
  logic  q_full;
  logic  q_empty;
  logic  pop;
  item_t q_item;

  ssi_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  ssi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .pop_item   (q_item),
    .empty      (q_empty)
  );

  ssi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- sv/ssi_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_front: command decode
// Takes words from the input channel, decodes the command, converts the
// coordinates and pushes the result into the queue. Unknown commands are
// taken and dropped.
// ----------------------------------------------------------------------------
module ssi_front import ssi_pkg::*; (
  ssi_in_if.sink in_ch,
  input  logic   q_full,
  output logic   push_valid,
  output item_t  push_item
);

  logic keep;
  op_t  op;

  always_comb begin
    keep = 1'b1;
    op   = OP_TEST;
    case (in_ch.command)
      CMD_LOAD: begin
        op = OP_LOAD;
      end
      CMD_CLEAR: begin
        op = OP_CLEAR;
      end
      CMD_TEST: begin
        op = OP_TEST;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = !q_full;
  assign push_valid  = in_ch.valid && !q_full && keep;

  assign push_item.op         = op;
  assign push_item.seg.xs     = to_coord(in_ch.x_start);
  assign push_item.seg.ys     = to_coord(in_ch.y_start);
  assign push_item.seg.xe     = to_coord(in_ch.x_end);
  assign push_item.seg.ye     = to_coord(in_ch.y_end);
  assign push_item.final_test = in_ch.final_test;

endmodule

// ----- sv/ssi_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_queue: short word queue between decode and execution
// A small first-in first-out buffer so that decode keeps taking words while
// a test is still running.
// ----------------------------------------------------------------------------
module ssi_queue import ssi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push_valid && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- sv/ssi_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_back: segment store and crossing test engine
// Executes load, clear and test words. A test walks the stored segments one
// per cycle through a four stage pipeline (read, differences, products,
// cross products) and ORs the range tests into the word's hit flag.
// ----------------------------------------------------------------------------
module ssi_back import ssi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  item_t      q_item,
  output logic       pop,
  ssi_out_if.source  out_ch
);

  seg_t        mem [MAX_SEGMENTS];
  logic        mem_we;

  back_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic        acc_r, acc_nxt;
  logic        item_hit_r, item_hit_nxt;
  logic        fin_r, fin_nxt;
  diff_t       nx_r, nx_nxt, ny_r, ny_nxt;
  coord_t      cxe_r, cxe_nxt, cye_r, cye_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        res_r, res_nxt;

  logic        issue;
  logic        pipe_busy;
  logic        pair_hit;
  logic        v_rd_r, v_diff_r, v_prod_r, v_cross_r;
  seg_t        rd_r;
  diff_t       mx_r, my_r, wx_r, wy_r;
  prod_t       p_mn0_r, p_mn1_r, p_tn0_r, p_tn1_r, p_sn0_r, p_sn1_r;
  cross_t      d_r, tn_r, sn_r;

  assign pipe_busy = v_rd_r || v_diff_r || v_prod_r || v_cross_r;
  assign issue     = (state_r == BK_RUN) && (idx_r < cnt_r);
  assign pair_hit  = (d_r != '0) && in_unit(tn_r, d_r) && in_unit(sn_r, d_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    item_hit_nxt  = item_hit_r;
    fin_nxt       = fin_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    cxe_nxt       = cxe_r;
    cye_nxt       = cye_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    pop           = 1'b0;
    mem_we        = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (q_item.op)
            OP_LOAD: begin
              if (cnt_r < CNT_W'(MAX_SEGMENTS)) begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            OP_TEST: begin
              idx_nxt      = '0;
              item_hit_nxt = 1'b0;
              fin_nxt      = q_item.final_test;
              nx_nxt       = DIFF_W'(q_item.seg.xe) - DIFF_W'(q_item.seg.xs);
              ny_nxt       = DIFF_W'(q_item.seg.ye) - DIFF_W'(q_item.seg.ys);
              cxe_nxt      = q_item.seg.xe;
              cye_nxt      = q_item.seg.ye;
              state_nxt    = BK_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      BK_RUN: begin
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (v_cross_r && pair_hit) begin
          item_hit_nxt = 1'b1;
        end
        if (!issue && !pipe_busy) begin
          state_nxt = BK_RESULT;
        end
      end
      BK_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt          = 1'b1;
          res_nxt.segment_hit    = item_hit_r;
          res_nxt.shapes_collide = fin_r && (acc_r || item_hit_r);
          res_nxt.run_done       = fin_r;
          acc_nxt                = fin_r ? 1'b0 : (acc_r || item_hit_r);
          state_nxt              = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      acc_r       <= 1'b0;
      item_hit_r  <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      v_rd_r      <= 1'b0;
      v_diff_r    <= 1'b0;
      v_prod_r    <= 1'b0;
      v_cross_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      item_hit_r  <= item_hit_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
      v_rd_r      <= issue;
      v_diff_r    <= v_rd_r;
      v_prod_r    <= v_diff_r;
      v_cross_r   <= v_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    cxe_r <= cxe_nxt;
    cye_r <= cye_nxt;
    res_r <= res_nxt;
  end

  // Segment store: written at the fill count, read at the walk index.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[ADDR_W-1:0]] <= q_item.seg;
    end
    rd_r <= mem[idx_r[ADDR_W-1:0]];
  end

  // Crossing pipeline. m is the stored direction, w runs from the test end
  // to the stored end.
  always_ff @(posedge clk) begin
    mx_r    <= DIFF_W'(rd_r.xe) - DIFF_W'(rd_r.xs);
    my_r    <= DIFF_W'(rd_r.ye) - DIFF_W'(rd_r.ys);
    wx_r    <= DIFF_W'(rd_r.xe) - DIFF_W'(cxe_r);
    wy_r    <= DIFF_W'(rd_r.ye) - DIFF_W'(cye_r);
    p_mn0_r <= PROD_W'(mx_r) * PROD_W'(ny_r);
    p_mn1_r <= PROD_W'(my_r) * PROD_W'(nx_r);
    p_tn0_r <= PROD_W'(wx_r) * PROD_W'(ny_r);
    p_tn1_r <= PROD_W'(wy_r) * PROD_W'(nx_r);
    p_sn0_r <= PROD_W'(wx_r) * PROD_W'(my_r);
    p_sn1_r <= PROD_W'(wy_r) * PROD_W'(mx_r);
    d_r     <= CROSS_W'(p_mn0_r) - CROSS_W'(p_mn1_r);
    tn_r    <= CROSS_W'(p_tn0_r) - CROSS_W'(p_tn1_r);
    sn_r    <= CROSS_W'(p_sn0_r) - CROSS_W'(p_sn1_r);
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.segment_hit    = res_r.segment_hit;
  assign out_ch.shapes_collide = res_r.shapes_collide;
  assign out_ch.run_done       = res_r.run_done;

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE) |-> !pipe_busy)
    else $error("crossing pipeline busy while engine idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count above store depth");

  a_collide_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.shapes_collide) |-> res_r.run_done)
    else $error("collision flag on a word that does not end the run");

  a_final_hit_collides: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.segment_hit && res_r.run_done) |-> res_r.shapes_collide)
    else $error("final word hit without collision flag");

  a_walk_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    v_rd_r |-> ($past(idx_r) < cnt_r))
    else $error("store read beyond fill count");

endmodule
